### rtl/bts_pkg.sv
`default_nettype none
package bts_pkg;

  localparam int SCORE_W        = 32;
  localparam int CAND_W         = 12;
  localparam int WIDTH_W        = 5;
  localparam int RANK_W         = 4;
  localparam int SLOT_W         = 13;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 5'd4;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [CAND_W-1:0]         candidate_index;
    logic                      last_candidate;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [SLOT_W-1:0]         source_slot;
    logic signed [SCORE_W-1:0] best_score;
    logic [WIDTH_W-1:0]        kept_count;
    logic                      last_result;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the newcomer, push lower entries down
    logic shift;   // move every entry one place toward the head
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } bts_state_t;

endpackage
`default_nettype wire

### rtl/bts_cell.sv
`default_nettype none
module bts_cell
  import bts_pkg::*;
#(
  parameter int INDEX_BITS = 12
) (
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic                      occupied,
  input  wire logic signed [SCORE_W-1:0] new_score,
  input  wire logic [INDEX_BITS-1:0]     new_idx,
  input  wire logic                      prev_ins,
  input  wire logic signed [SCORE_W-1:0] prev_score,
  input  wire logic [INDEX_BITS-1:0]     prev_idx,
  input  wire logic signed [SCORE_W-1:0] next_score,
  input  wire logic [INDEX_BITS-1:0]     next_idx,
  output logic                           ins,
  output logic signed [SCORE_W-1:0]      score,
  output logic [INDEX_BITS-1:0]          idx
);

  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [INDEX_BITS-1:0]     idx_r, idx_nxt;

  // newcomer lands at or above this cell; ties stay behind the held entry
  assign ins = !occupied || (new_score > score_r);

  always_comb begin
    score_nxt = score_r;
    idx_nxt   = idx_r;
    if (ctrl.shift) begin
      score_nxt = next_score;
      idx_nxt   = next_idx;
    end else if (ctrl.insert && ins) begin
      if (prev_ins) begin
        score_nxt = prev_score;
        idx_nxt   = prev_idx;
      end else begin
        score_nxt = new_score;
        idx_nxt   = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    idx_r   <= idx_nxt;
  end

  assign score = score_r;
  assign idx   = idx_r;

endmodule
`default_nettype wire

### rtl/beam_top_k_selector.sv
`default_nettype none
// Streaming top-k selector for beam search. Candidates (signed Q16.16 score plus
// index) arrive one per cycle and are sorted on the fly into a chain of MAX_BEAM
// cells, best score at the head; equal scores keep arrival order, and a newcomer
// that does not beat the lowest of a full chain is dropped. The transfer marked
// last_candidate is included and then closes the set: the block stops taking
// input and emits n = min(candidates held, beam width) results, best first, one
// per output transfer, after which the chain is empty and input resumes. While
// results go out, the chain drains one entry toward its head per output
// transfer. A result waits in an output register, so input reopens as soon as
// the final one is loaded. beam_width (cfg_wr_data, reset 4) is read when the
// last candidate arrives; zero acts as one and values above MAX_BEAM act as
// MAX_BEAM. source_slot is effective width plus candidate index, modulo 2^13.
module beam_top_k_selector
  import bts_pkg::*;
#(
  parameter int MAX_BEAM   = 16,
  parameter int INDEX_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [WIDTH_W-1:0] cfg_wr_data,
  input  wire logic               in_valid,
  input  wire in_item_t           in_item,
  output logic                    in_stall,
  output logic                    out_valid,
  output out_item_t               out_item,
  input  wire logic               out_stall
);

  localparam int FILL_W = $clog2(MAX_BEAM + 1);
  localparam int CMP_W  = (FILL_W > WIDTH_W) ? FILL_W : WIDTH_W;

  // control state
  bts_state_t         state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [WIDTH_W-1:0] k_r, k_nxt;          // index of the next result
  logic [WIDTH_W-1:0] n_r, n_nxt;          // results in this run
  logic [WIDTH_W-1:0] w_r, w_nxt;          // effective width latched at last
  logic [WIDTH_W-1:0] beam_width_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               in_xfer;
  logic               out_load;
  logic [FILL_W-1:0]  fill_after;
  logic [WIDTH_W-1:0] w_eff;
  cell_ctrl_t         ctrl;

  // cell chain wiring
  logic [MAX_BEAM-1:0]             ins;
  logic [MAX_BEAM-1:0]             occ;
  logic signed [SCORE_W-1:0]       c_score [MAX_BEAM];
  logic [INDEX_BITS-1:0]           c_idx   [MAX_BEAM];
  logic [INDEX_BITS-1:0]           new_idx;

  assign in_stall = (state_r != ST_COLLECT);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign new_idx  = INDEX_BITS'(in_item.candidate_index);

  assign ctrl.insert = in_xfer;
  assign ctrl.shift  = out_load;

  for (genvar i = 0; i < MAX_BEAM; i++) begin : g_cell
    // cell i holds an entry when it sits below the fill level
    assign occ[i] = (FILL_W'(i) < fill_r);

    if (i == 0) begin : g_head
      bts_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ[i]),
        .new_score  (in_item.score),
        .new_idx    (new_idx),
        .prev_ins   (1'b0),
        .prev_score (in_item.score),
        .prev_idx   (new_idx),
        .next_score (c_score[(i + 1) % MAX_BEAM]),
        .next_idx   (c_idx[(i + 1) % MAX_BEAM]),
        .ins        (ins[i]),
        .score      (c_score[i]),
        .idx        (c_idx[i])
      );
    end else if (i == MAX_BEAM - 1) begin : g_tail
      bts_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ[i]),
        .new_score  (in_item.score),
        .new_idx    (new_idx),
        .prev_ins   (ins[i - 1]),
        .prev_score (c_score[i - 1]),
        .prev_idx   (c_idx[i - 1]),
        .next_score (c_score[i]),
        .next_idx   (c_idx[i]),
        .ins        (ins[i]),
        .score      (c_score[i]),
        .idx        (c_idx[i])
      );
    end else begin : g_mid
      bts_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ[i]),
        .new_score  (in_item.score),
        .new_idx    (new_idx),
        .prev_ins   (ins[i - 1]),
        .prev_score (c_score[i - 1]),
        .prev_idx   (c_idx[i - 1]),
        .next_score (c_score[i + 1]),
        .next_idx   (c_idx[i + 1]),
        .ins        (ins[i]),
        .score      (c_score[i]),
        .idx        (c_idx[i])
      );
    end
  end

  // fill saturates once the chain is full
  assign fill_after = (fill_r == FILL_W'(MAX_BEAM)) ? fill_r : fill_r + 1'b1;

  // clamp configured width into 1..MAX_BEAM
  always_comb begin
    if (beam_width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (CMP_W'(beam_width_r) > CMP_W'(MAX_BEAM)) begin
      w_eff = WIDTH_W'(MAX_BEAM);
    end else begin
      w_eff = beam_width_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_COLLECT: begin
        if (in_xfer) begin
          fill_nxt = fill_after;
          if (in_item.last_candidate) begin
            state_nxt = ST_EMIT;
            k_nxt     = '0;
            w_nxt     = w_eff;
            if (CMP_W'(fill_after) < CMP_W'(w_eff)) begin
              n_nxt = WIDTH_W'(fill_after);
            end else begin
              n_nxt = w_eff;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.rank        = RANK_W'(k_r);
          out_item_nxt.source_slot = SLOT_W'(w_r) + SLOT_W'(c_idx[0]);
          out_item_nxt.best_score  = c_score[0];
          out_item_nxt.kept_count  = n_r;
          out_item_nxt.last_result = (k_r == n_r - 1'b1);
          k_nxt                    = k_r + 1'b1;
          // final result loaded: list is cleared and input reopens
          if (k_r == n_r - 1'b1) begin
            state_nxt = ST_COLLECT;
            fill_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      fill_r       <= '0;
      k_r          <= '0;
      n_r          <= '0;
      w_r          <= '0;
      out_valid_r  <= 1'b0;
      beam_width_r <= WIDTH_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        beam_width_r <= cfg_wr_data;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
